// ----- sv/xoshiro_ranged_random_list_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the ranged random list generator
// Implication checks on clk with rst as disable.
// ----------------------------------------------------------------------------
`ifndef XOSHIRO_RANGED_RANDOM_LIST_ASSERT_SVH
`define XOSHIRO_RANGED_RANDOM_LIST_ASSERT_SVH

// same-cycle implication
`define XRRL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define XRRL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/xrrl_pkg.sv -----
// ----------------------------------------------------------------------------
// xrrl_pkg
// Types and constants for the ranged random list generator.
// ----------------------------------------------------------------------------
package xrrl_pkg;

  localparam int WORD_W        = 32;
  localparam int COUNT_W       = 7;
  localparam int COUNT_MAX_DEF = 64;
  localparam int DIV_STEPS     = WORD_W;
  localparam int STEP_W        = $clog2(DIV_STEPS);

  typedef struct packed {
    logic        [WORD_W-1:0]  seed_word0;
    logic        [WORD_W-1:0]  seed_word1;
    logic        [WORD_W-1:0]  seed_word2;
    logic        [WORD_W-1:0]  seed_word3;
    logic signed [WORD_W-1:0]  range_min;
    logic signed [WORD_W-1:0]  range_max;
    logic        [COUNT_W-1:0] draw_count;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] draw_value;
    logic                     last_draw;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_MIX,
    ST_DIV,
    ST_EMIT
  } state_t;

endpackage

// ----- sv/xoshiro_ranged_random_list.sv -----
// ----------------------------------------------------------------------------
// xoshiro_ranged_random_list
// Seeded xoshiro128** generator producing a list of values in a range.
// ----------------------------------------------------------------------------
// Each request item loads the four seed words as the generator state and
// asks for draw_count values (saturated to COUNT_MAX). Each value is
// range_min + (raw mod span), span = range_max - range_min + 1 taken as an
// unsigned 32-bit word; the sum wraps to 32 bits. A zero span (full range)
// adds the raw output unreduced, and max below min simply wraps. A count of
// zero gives no result items. Each draw steps through ST_MUL and ST_MIX for
// the generator step and output scrambler (shift-add multiplies by 5 and 9),
// ST_DIV for the bit-serial restoring divider that forms the remainder, and
// ST_EMIT, which loads the output register once it is empty or not stalled
// (a zero span skips the divider). The request side stalls for the whole
// request; the last result sits in the output register, so the next request
// is taken while it waits.
// ----------------------------------------------------------------------------
module xoshiro_ranged_random_list #(
  parameter int COUNT_MAX = xrrl_pkg::COUNT_MAX_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  xrrl_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output xrrl_pkg::rsp_t rsp
);

  import xrrl_pkg::*;

  localparam int CNT_W = $clog2(COUNT_MAX + 1);

  // sequencer
  state_t state, state_next;

  // generator state and per-request operands
  logic [WORD_W-1:0] s0, s1, s2, s3;
  logic [WORD_W-1:0] lo;
  logic [WORD_W-1:0] span;
  logic [CNT_W-1:0]  left;

  // scrambler and divider
  logic [WORD_W-1:0] m5;      // s1 * 5
  logic [WORD_W-1:0] dvd;     // dividend, shifted out msb first
  logic [WORD_W-1:0] rem;     // partial remainder, final reduced value
  logic [STEP_W-1:0] step;

  logic              req_take;
  logic              rsp_load;
  logic              span_zero;
  logic [CNT_W-1:0]  count_sat;
  logic [WORD_W-1:0] rot7;
  logic [WORD_W-1:0] raw;
  logic [WORD_W:0]   trial;
  logic [WORD_W:0]   diff;

  assign req_take  = req_valid && !req_stall;
  assign span_zero = (span == '0);
  assign count_sat = (req.draw_count > COUNT_W'(COUNT_MAX)) ? CNT_W'(COUNT_MAX)
                                                           : CNT_W'(req.draw_count);

  // rotl(s1*5, 7) * 9
  assign rot7 = {m5[WORD_W-8:0], m5[WORD_W-1:WORD_W-7]};
  assign raw  = rot7 + {rot7[WORD_W-4:0], 3'b000};

  // one restoring divide step
  assign trial = {rem, dvd[WORD_W-1]};
  assign diff  = trial - {1'b0, span};

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake outputs
  always_comb begin
    state_next = state;
    req_stall  = 1'b1;
    rsp_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid && count_sat != '0) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_MIX;
      end
      ST_MIX: begin
        state_next = span_zero ? ST_EMIT : ST_DIV;
      end
      ST_DIV: begin
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_load   = 1'b1;
          state_next = (left == CNT_W'(1)) ? ST_IDLE : ST_MUL;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // count of draws still to emit
  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
    end else if (req_take) begin
      left <= count_sat;
    end else if (rsp_load) begin
      left <= left - CNT_W'(1);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        s0   <= req.seed_word0;
        s1   <= req.seed_word1;
        s2   <= req.seed_word2;
        s3   <= req.seed_word3;
        lo   <= req.range_min;
        span <= req.range_max - req.range_min + WORD_W'(1);
      end
      ST_MUL: begin
        // scrambler front half and the xoshiro state update
        m5 <= s1 + {s1[WORD_W-3:0], 2'b00};
        s2 <= s2 ^ s0 ^ {s1[WORD_W-10:0], 9'd0};
        s1 <= s1 ^ s2 ^ s0;
        s0 <= s0 ^ s3 ^ s1;
        s3 <= {s3[WORD_W-12:0] ^ s1[WORD_W-12:0],
               s3[WORD_W-1:WORD_W-11] ^ s1[WORD_W-1:WORD_W-11]};
      end
      ST_MIX: begin
        dvd  <= raw;
        rem  <= span_zero ? raw : '0;
        step <= '0;
      end
      ST_DIV: begin
        rem  <= diff[WORD_W] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];
        dvd  <= {dvd[WORD_W-2:0], 1'b0};
        step <= step + STEP_W'(1);
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.draw_value <= $signed(lo + rem);
      rsp.last_draw  <= (left == CNT_W'(1));
    end
  end

`include "xoshiro_ranged_random_list_assert.svh"

  `XRRL_ASSERT_NOW(a_rem_below_span, state == ST_DIV, rem < span, "remainder not below span")
  `XRRL_ASSERT_NOW(a_busy_has_work, state != ST_IDLE, left != '0, "busy with no draws left")
  `XRRL_ASSERT_NEXT(a_zero_count_idle, req_take && count_sat == '0,
                    state == ST_IDLE && left == '0, "empty request started work")
  `XRRL_ASSERT_NEXT(a_last_flag, rsp_load && left == CNT_W'(1),
                    state == ST_IDLE && rsp_valid && rsp.last_draw, "final draw not flagged")

endmodule

// ----- tb/tb_xoshiro_ranged_random_list.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_xoshiro_ranged_random_list
// Self-checking bench for the seeded xoshiro128** ranged list generator.
// ----------------------------------------------------------------------------
// Requests go in on the req channel and each one is predicted in full when it
// is accepted: the bench keeps its own copy of the generator state, steps it
// draw_count times (saturated) and queues one expected value per step. Values
// leaving on the rsp channel are matched, oldest first, against that queue.
// A short directed set covers the range and count corner cases, then random
// requests run under three idling mixes, with a long output hold-off in the
// last one so that the block fills and stalls its request side.
// ----------------------------------------------------------------------------

class draw_ledger;
  xrrl_pkg::rsp_t expected_draws[$];
  int unsigned    mismatches = 0;
  int unsigned    draws_seen = 0;

  // Run the generator for one request and queue every value it should give.
  function void note_request(xrrl_pkg::req_t r);
    logic [31:0]    s0, s1, s2, s3;
    logic [31:0]    t, mul5, raw, span, red;
    int unsigned    n;
    xrrl_pkg::rsp_t d;
    s0   = r.seed_word0;
    s1   = r.seed_word1;
    s2   = r.seed_word2;
    s3   = r.seed_word3;
    span = r.range_max - r.range_min + 32'd1;
    n    = (r.draw_count > xrrl_pkg::COUNT_MAX_DEF) ? xrrl_pkg::COUNT_MAX_DEF
                                                     : r.draw_count;
    for (int unsigned k = 0; k < n; k++) begin
      mul5 = s1 * 32'd5;
      raw  = {mul5[24:0], mul5[31:25]} * 32'd9;
      t    = s1 << 9;
      s2   = s2 ^ s0;
      s3   = s3 ^ s1;
      s1   = s1 ^ s2;
      s0   = s0 ^ s3;
      s2   = s2 ^ t;
      s3   = {s3[20:0], s3[31:21]};
      // zero span means the full 32-bit range: no reduction
      red  = (span == 32'd0) ? raw : raw % span;
      d.draw_value = r.range_min + red;
      d.last_draw  = (k + 1 == n);
      expected_draws.push_back(d);
    end
  endfunction

  task report(string msg);
    if (mismatches < 100) $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task check_draw(xrrl_pkg::rsp_t got);
    xrrl_pkg::rsp_t want;
    if (expected_draws.size() == 0) begin
      report($sformatf("unexpected draw, value %h last %b", got.draw_value, got.last_draw));
      return;
    end
    want = expected_draws.pop_front();
    if (got.draw_value !== want.draw_value)
      report($sformatf("draw %0d: value %h, predicted %h",
                       draws_seen, got.draw_value, want.draw_value));
    if (got.last_draw !== want.last_draw)
      report($sformatf("draw %0d: last_draw %b, predicted %b",
                       draws_seen, got.last_draw, want.last_draw));
    draws_seen++;
  endtask
endclass

module tb_xoshiro_ranged_random_list;

  localparam int unsigned CYCLE_LIMIT     = 5_000_000;
  localparam int unsigned HOLD_OFF_CYCLES = 3000;
  localparam int unsigned DRAIN_CYCLES    = 200;
  localparam int unsigned RANDOM_PER_MIX  = 67;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_stall;
  xrrl_pkg::req_t req = '0;
  logic           rsp_valid;
  logic           rsp_stall = 1'b0;
  xrrl_pkg::rsp_t rsp;

  // idling odds in percent, changed only between mixes by the main process
  int unsigned    send_idle = 0;
  int unsigned    recv_idle = 0;

  // hold-off: armed by the main process, counted by the receiver
  logic           hold_off_armed = 1'b0;
  int unsigned    hold_count = 0;
  bit             hold_done = 1'b0;

  int unsigned    cycle_count = 0;
  draw_ledger     ledger;

  xoshiro_ranged_random_list i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Watchdog: a hung block never drains its queue, so stop after the limit.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_xoshiro_ranged_random_list: FAIL");
    $finish;
  end

  // Receiver: check each item taken at this edge, then pick next cycle's stall.
  // Outputs are read straight after the edge, before any register updates land.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall)
      ledger.check_draw(rsp);
    if (hold_off_armed && !hold_done) begin
      // long stall so the output register and the request side back up
      rsp_stall <= 1'b1;
      hold_count++;
      if (hold_count >= HOLD_OFF_CYCLES) hold_done = 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  function automatic xrrl_pkg::req_t make_request(logic [31:0] s0, logic [31:0] s1,
                                                  logic [31:0] s2, logic [31:0] s3,
                                                  logic [31:0] lo, logic [31:0] hi,
                                                  logic [6:0] n);
    xrrl_pkg::req_t r;
    r.seed_word0 = s0;
    r.seed_word1 = s1;
    r.seed_word2 = s2;
    r.seed_word3 = s3;
    r.range_min  = lo;
    r.range_max  = hi;
    r.draw_count = n;
    return r;
  endfunction

  // Random request: mostly small counts, with the odd full or saturated one.
  function automatic xrrl_pkg::req_t random_request();
    logic [31:0] s0, s1, s2, s3, lo, hi;
    logic [6:0]  n;
    int unsigned pick;
    s0 = $urandom;
    s1 = $urandom;
    s2 = $urandom;
    s3 = $urandom;
    if ($urandom_range(19) == 0) begin
      s0 = '0; s1 = '0; s2 = '0; s3 = '0;
    end
    lo = $urandom;
    case ($urandom_range(9))
      0, 1, 2, 3: hi = lo + $urandom_range(1000);
      4, 5:       hi = $urandom;
      6: begin
        lo = 32'h8000_0000;
        hi = 32'h7FFF_FFFF;
      end
      7:          hi = lo - 32'd1 - $urandom_range(1000);
      8:          hi = lo + (32'd1 << $urandom_range(31)) - 32'd1;
      default:    hi = lo;
    endcase
    pick = $urandom_range(99);
    if (pick < 8)       n = 7'd0;
    else if (pick < 70) n = 7'($urandom_range(12, 1));
    else if (pick < 90) n = 7'($urandom_range(63, 13));
    else if (pick < 96) n = 7'd64;
    else                n = 7'($urandom_range(127, 65));
    return make_request(s0, s1, s2, s3, lo, hi, n);
  endfunction

  // Offer one item, with random idle cycles first; hold it until taken.
  // valid stays high straight into the next item when no gap is drawn.
  task automatic send_request(xrrl_pkg::req_t r);
    while ($urandom_range(99) < send_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall !== 1'b0);
    ledger.note_request(r);
  endtask

  initial begin
    ledger = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed set, under the first idling mix
    send_idle = 34;
    recv_idle = 76;
    // all-zero seed: generator gives zeros, so every value is the minimum
    send_request(make_request('0, '0, '0, '0, 32'd0, 32'd100, 7'd5));
    // full range, zero span: raw output passes through
    send_request(make_request('1, '1, '1, '1, 32'h8000_0000, 32'h7FFF_FFFF, 7'd4));
    // max below min, small wrap
    send_request(make_request(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F,
                              32'hF0F0_F0F0, 32'd100, -32'sd100, 7'd3));
    // max below min with sums that wrap past the top
    send_request(make_request(32'hDEAD_BEEF, 32'h0BAD_F00D, 32'hCAFE_BABE,
                              32'h8BAD_F00D, 32'h7FFF_FF00, 32'h0000_0100, 7'd6));
    // count of zero
    send_request(make_request(32'h1, 32'h2, 32'h3, 32'h4, 32'd0, 32'd9, 7'd0));
    // count at the ceiling
    send_request(make_request(32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h3C3C_3C3C,
                              32'hC3C3_C3C3, -32'sd50, 32'd50, 7'd64));
    // counts above the ceiling saturate
    send_request(make_request(32'h0000_0001, 32'h8000_0000, 32'h0000_0000,
                              32'h7FFF_FFFF, 32'd0, 32'd255, 7'd65));
    send_request(make_request(32'hFFFF_FFFE, 32'h0000_0001, 32'h1357_9BDF,
                              32'h2468_ACE0, 32'd1, 32'd6, 7'd127));
    // single-value ranges
    send_request(make_request(32'h0101_0101, 32'h1010_1010, 32'h0, 32'h1,
                              32'h8000_0000, 32'h8000_0000, 7'd3));
    send_request(make_request(32'h0202_0202, 32'h2020_2020, 32'h3, 32'h0,
                              32'h7FFF_FFFF, 32'h7FFF_FFFF, 7'd3));
    // span of 2^32 - 1 and of 2^31
    send_request(make_request(32'h7654_3210, 32'hFEDC_BA98, 32'h0123_4567,
                              32'h89AB_CDEF, 32'h8000_0000, 32'h7FFF_FFFE, 7'd4));
    send_request(make_request(32'h1111_1111, 32'h2222_2222, 32'h3333_3333,
                              32'h4444_4444, 32'd0, 32'h7FFF_FFFF, 7'd4));
    // single seed bits set
    send_request(make_request(32'h0, 32'h1, 32'h0, 32'h0, 32'd0, 32'hFFFF, 7'd2));
    send_request(make_request(32'h0, 32'h0, 32'h0, 32'h8000_0000, -32'sd1, 32'd1, 7'd8));
    // one draw and two draws back to back
    send_request(make_request($urandom, $urandom, $urandom, $urandom,
                              -32'sd1000, 32'd1000, 7'd1));
    send_request(make_request($urandom, $urandom, $urandom, $urandom,
                              32'd3, 32'd3, 7'd2));

    // random part, first mix: sender idles less than receiver
    for (int i = 0; i < RANDOM_PER_MIX; i++) send_request(random_request());

    // second mix: the other way round
    send_idle = 76;
    recv_idle = 34;
    for (int i = 0; i < RANDOM_PER_MIX; i++) send_request(random_request());

    // third mix: no idling, plus one long output hold-off at its start
    send_idle      = 0;
    recv_idle      = 0;
    hold_off_armed <= 1'b1;
    for (int i = 0; i < RANDOM_PER_MIX; i++) send_request(random_request());
    req_valid <= 1'b0;

    while (ledger.expected_draws.size() != 0) @(posedge clk);
    // catch any stray item that follows the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (ledger.mismatches == 0)
      $display("tb_xoshiro_ranged_random_list: PASS");
    else
      $display("tb_xoshiro_ranged_random_list: FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/xrrl_pkg.sv
sv/xoshiro_ranged_random_list.sv
tb/tb_xoshiro_ranged_random_list.sv
